@@ hdl/oof_pkg.sv @@
// Shared types and constants of the optical flow odometry filter.
package oof_pkg;

  localparam int unsigned POS_W       = 32;
  localparam int unsigned SCALE_NUM_W = 16;
  localparam int unsigned SCALED_W    = 16;

  localparam logic [SCALE_NUM_W-1:0] SCALE_NUM_RESET = 16'd889;

  // Status byte bit positions
  localparam int unsigned STATUS_MOTION_BIT   = 7;
  localparam int unsigned STATUS_OVERFLOW_BIT = 4;

  // Divisor 768 = 256 * 3: shift by 8, then exact divide by 3
  localparam int unsigned SCALE_SHIFT = 8;
  localparam logic [SCALED_W-1:0] INV3_MOD16 = 16'hAAAB;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } totals_t;

  typedef struct packed {
    logic    valid;
    totals_t totals;
  } totals_beat_t;

  typedef struct packed {
    logic                   valid;
    logic signed [SCALED_W-1:0] x;
    logic signed [SCALED_W-1:0] y;
  } scaled_beat_t;

endpackage

@@ hdl/oof_in_if.sv @@
// Input channel: one motion report per transfer.
interface oof_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        motion_status;
  logic signed [7:0] delta_x;
  logic signed [7:0] delta_y;

  modport source (output valid, motion_status, delta_x, delta_y, input ready);
  modport sink   (input valid, motion_status, delta_x, delta_y, output ready);
endinterface

@@ hdl/oof_out_if.sv @@
// Output channel: one filtered position per transfer.
interface oof_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] filtered_x;
  logic signed [15:0] filtered_y;

  modport source (output valid, filtered_x, filtered_y, input ready);
  modport sink   (input valid, filtered_x, filtered_y, output ready);
endinterface

@@ hdl/oof_front.sv @@
// Front end: accepts reports, accumulates position totals, classifies motion.
module oof_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  oof_in_if.sink               in_i,
  input  logic                 q_full_i,
  output oof_pkg::totals_beat_t push_o
);
  import oof_pkg::*;

  logic signed [POS_W-1:0] tot_x_q, tot_x_d;
  logic signed [POS_W-1:0] tot_y_q, tot_y_d;
  logic                    accept;
  logic                    motion_ok;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  // Wrapping totals, sign-extended deltas
  assign tot_x_d = tot_x_q + POS_W'(in_i.delta_x);
  assign tot_y_d = tot_y_q + POS_W'(in_i.delta_y);

  // Motion seen and no overflow: this report updates the window
  assign motion_ok = in_i.motion_status[STATUS_MOTION_BIT] &&
                     !in_i.motion_status[STATUS_OVERFLOW_BIT];

  assign push_o.valid    = accept && motion_ok;
  assign push_o.totals.x = tot_x_d;
  assign push_o.totals.y = tot_y_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_x_q <= '0;
      tot_y_q <= '0;
    end else if (accept) begin
      tot_x_q <= tot_x_d;
      tot_y_q <= tot_y_d;
    end
  end

endmodule

@@ hdl/oof_queue.sv @@
// Short FIFO of position totals between front end and back end.
module oof_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  oof_pkg::totals_beat_t push_i,
  input  logic                  pop_i,
  output logic                  full_o,
  output oof_pkg::totals_beat_t head_o
);
  import oof_pkg::*;

  totals_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q;
  logic [QPTR_W-1:0] rd_q;
  logic [QPTR_W:0]   count_q;
  logic              do_pop;

  assign full_o        = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_o.valid  = (count_q != '0);
  assign head_o.totals = mem[rd_q];
  assign do_pop        = pop_i && head_o.valid;

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem[wr_q] <= push_i.totals;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i.valid) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      count_q <= count_q + (QPTR_W+1)'(push_i.valid) - (QPTR_W+1)'(do_pop);
    end
  end

endmodule

@@ hdl/oof_scale.sv @@
// Back end, first half: scales totals to millimetres (x * num / 768).
module oof_scale (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  oof_pkg::totals_beat_t              head_i,
  input  logic [oof_pkg::SCALE_NUM_W-1:0]    num_i,
  output oof_pkg::scaled_beat_t              res_o
);
  import oof_pkg::*;

  localparam int unsigned PROD_W = POS_W + SCALE_NUM_W + 1;
  localparam int unsigned QIN_W  = PROD_W - 2 - SCALE_SHIFT;

  // Remainder by 3 via base-4 digit sums (4 = 1 mod 3)
  function automatic logic [1:0] mod3(input logic [QIN_W-1:0] v);
    logic [39:0] w;
    logic [3:0]  grp [4];
    logic [5:0]  s;
    logic [3:0]  t;
    logic [2:0]  u;
    w = 40'(v);
    for (int g = 0; g < 4; g++) begin
      grp[g] = '0;
      for (int d = 0; d < 5; d++) begin
        grp[g] = grp[g] + 4'(w[2*(g*5+d) +: 2]);
      end
    end
    s = 6'(grp[0]) + 6'(grp[1]) + 6'(grp[2]) + 6'(grp[3]);
    t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
    u = 3'(t[1:0]) + 3'(t[3:2]);
    return (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
  endfunction

  logic signed [POS_W-1:0]  tot [2];
  logic signed [PROD_W-1:0] prod_q [2];
  logic [PROD_W-1:0]        mag [2];
  logic [QIN_W-1:0]         quo_in_q [2];
  logic                     neg2_q [2];
  logic [SCALED_W-1:0]      low_q [2];
  logic                     neg3_q [2];
  logic [SCALED_W-1:0]      q_abs [2];
  logic [SCALED_W-1:0]      scaled_q [2];
  logic                     v1_q, v2_q, v3_q, v4_q;

  assign tot[0] = head_i.totals.x;
  assign tot[1] = head_i.totals.y;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      mag[k]   = prod_q[k][PROD_W-1] ? PROD_W'(-prod_q[k]) : PROD_W'(prod_q[k]);
      q_abs[k] = SCALED_W'(low_q[k] * INV3_MOD16);
    end
  end

  // Datapath stages, all advancing together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 2; k++) begin
        // multiply by unsigned numerator
        prod_q[k]   <= PROD_W'(tot[k]) * $signed(PROD_W'({1'b0, num_i}));
        // magnitude, divide by 256
        quo_in_q[k] <= mag[k][SCALE_SHIFT +: QIN_W];
        neg2_q[k]   <= prod_q[k][PROD_W-1];
        // exact divide by 3, low bits only
        low_q[k]    <= quo_in_q[k][SCALED_W-1:0] - SCALED_W'(mod3(quo_in_q[k]));
        neg3_q[k]   <= neg2_q[k];
        // restore sign, wrap to 16 bits
        scaled_q[k] <= neg3_q[k] ? -q_abs[k] : q_abs[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= head_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign res_o.valid = v4_q;
  assign res_o.x     = $signed(scaled_q[0]);
  assign res_o.y     = $signed(scaled_q[1]);

endmodule

@@ hdl/oof_window.sv @@
// Back end, second half: moving window sums, average and output register.
module oof_window #(
  parameter int unsigned WINDOW_LENGTH = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  oof_pkg::scaled_beat_t in_i,
  output logic                  en_o,
  oof_out_if.source             out_o
);
  import oof_pkg::*;

  localparam int unsigned L      = $clog2(WINDOW_LENGTH);
  localparam int unsigned PTR_W  = (WINDOW_LENGTH > 1) ? L : 1;
  localparam int unsigned MAG_W  = SCALED_W + L;
  localparam int unsigned SUM_W  = MAG_W + 1;
  localparam int unsigned SH     = SCALED_W + 2 * L;
  localparam int unsigned RCP_W  = SCALED_W + 1 + L;
  localparam int unsigned MUL_W  = MAG_W + RCP_W;
  localparam longint unsigned RCP_FULL =
    ((64'd1 << SH) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_FULL);

  logic signed [SCALED_W-1:0] win_x_q [WINDOW_LENGTH];
  logic signed [SCALED_W-1:0] win_y_q [WINDOW_LENGTH];
  logic [PTR_W-1:0]           ptr_q;
  logic signed [SUM_W-1:0]    sum_x_q, sum_y_q;
  logic                       v1_q, v2_q, v3_q, out_valid_q;
  logic [MAG_W-1:0]           mag_x_q, mag_y_q;
  logic                       neg_x2_q, neg_y2_q, neg_x3_q, neg_y3_q;
  logic [MUL_W-1:0]           mul_x_q, mul_y_q;
  logic [SCALED_W-1:0]        q_x, q_y;
  logic signed [SCALED_W-1:0] out_x_q, out_y_q;
  logic                       take;

  // Whole back end moves when the output register is free or being drained
  assign en_o = !out_valid_q || out_o.ready;
  assign take = en_o && in_i.valid;

  // Window update: replace oldest entry, adjust running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        win_x_q[i] <= '0;
        win_y_q[i] <= '0;
      end
      ptr_q   <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
    end else if (take) begin
      win_x_q[ptr_q] <= in_i.x;
      win_y_q[ptr_q] <= in_i.y;
      sum_x_q <= sum_x_q + SUM_W'(in_i.x) - SUM_W'(win_x_q[ptr_q]);
      sum_y_q <= sum_y_q + SUM_W'(in_i.y) - SUM_W'(win_y_q[ptr_q]);
      ptr_q   <= (ptr_q == PTR_W'(WINDOW_LENGTH - 1)) ? '0 : ptr_q + 1'b1;
    end
  end

  assign q_x = mul_x_q[SH +: SCALED_W];
  assign q_y = mul_y_q[SH +: SCALED_W];

  // Average: magnitude, reciprocal multiply, shift and sign
  always_ff @(posedge clk_i) begin
    if (en_o) begin
      neg_x2_q <= sum_x_q[SUM_W-1];
      neg_y2_q <= sum_y_q[SUM_W-1];
      mag_x_q  <= sum_x_q[SUM_W-1] ? MAG_W'(-sum_x_q) : MAG_W'(sum_x_q);
      mag_y_q  <= sum_y_q[SUM_W-1] ? MAG_W'(-sum_y_q) : MAG_W'(sum_y_q);
      neg_x3_q <= neg_x2_q;
      neg_y3_q <= neg_y2_q;
      mul_x_q  <= MUL_W'(mag_x_q) * MUL_W'(RCP);
      mul_y_q  <= MUL_W'(mag_y_q) * MUL_W'(RCP);
      out_x_q  <= neg_x3_q ? $signed(-q_x) : $signed(q_x);
      out_y_q  <= neg_y3_q ? $signed(-q_y) : $signed(q_y);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_o) begin
      v1_q        <= in_i.valid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.filtered_x = out_x_q;
  assign out_o.filtered_y = out_y_q;

endmodule

@@ hdl/optical_flow_odometry_filter.sv @@
// Throughput unless the output stalls: one report per cycle; the scale and
// averaging pipelines take a new item every cycle, and a 4-entry queue decouples
// intake from output stalls. Results are registered through queue and pipelines.
// Reports without motion, or with overflow, update the totals and give no result.
// Reset (rst_ni low, asynchronous) clears totals, window, sums and pointer and
// loads the scale numerator with 889.
module optical_flow_odometry_filter #(
  parameter int unsigned WINDOW_LENGTH = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  oof_in_if.sink      in_i,
  oof_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [oof_pkg::SCALE_NUM_W-1:0] cfg_wdata_i
);
  import oof_pkg::*;

  logic [SCALE_NUM_W-1:0] num_q;
  totals_beat_t           push;
  totals_beat_t           head;
  scaled_beat_t           scaled;
  logic                   q_full;
  logic                   pipe_en;

  // Scale numerator register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= SCALE_NUM_RESET;
    end else if (cfg_we_i) begin
      num_q <= cfg_wdata_i;
    end
  end

  oof_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  oof_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pipe_en),
    .full_o (q_full),
    .head_o (head)
  );

  oof_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .head_i (head),
    .num_i  (num_q),
    .res_o  (scaled)
  );

  oof_window #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (scaled),
    .en_o   (pipe_en),
    .out_o  (out_o)
  );

endmodule
